@@ src/char_lcd_cursor_bus_writer_unit_assert.svh @@
// Assertion macros shared by the character-LCD bus writer RTL.
// Define ASSERT_OFF to compile the checks out; no other dependencies.
`ifndef CHAR_LCD_CURSOR_BUS_WRITER_UNIT_ASSERT_SVH
`define CHAR_LCD_CURSOR_BUS_WRITER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define CLBW_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("clbw assertion failed");

// Condition must never be seen outside reset.
`define CLBW_ASSERT_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("clbw forbidden condition seen");

`else

`define CLBW_ASSERT(label, clk, rstn, prop)
`define CLBW_ASSERT_NEVER(label, clk, rstn, cond)

`endif

`endif

@@ src/clbw_pkg.sv @@
// Shared types, codes and the set-address helper for the LCD bus writer.
// No dependencies.
`default_nettype none

package clbw_pkg;

    localparam logic [1:0] CMD_WRITE_CHAR = 2'd0;
    localparam logic [1:0] CMD_SET_CURSOR = 2'd1;
    localparam logic [1:0] CMD_RAW_CMD    = 2'd2;
    localparam logic [1:0] CMD_RAW_DATA   = 2'd3;

    localparam logic [1:0] CFG_IDX_FOUR_BIT = 2'd0;
    localparam logic [1:0] CFG_IDX_WIDTH    = 2'd1;
    localparam logic [1:0] CFG_IDX_HEIGHT   = 2'd2;

    localparam logic       RS_COMMAND = 1'b0;
    localparam logic       RS_DATA    = 1'b1;

    localparam logic [6:0] ROW_ODD_OFFSET = 7'h40;
    localparam logic [7:0] SET_ADDR_FLAG  = 8'h80;

    localparam logic       RESET_FOUR_BIT = 1'b1;
    localparam logic [5:0] RESET_WIDTH    = 6'd16;
    localparam logic [2:0] RESET_HEIGHT   = 3'd2;

    // queue depth, power of two
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    typedef struct packed {
        logic       four_bit_mode;
        logic [5:0] width;
        logic [2:0] height;
    } cfg_t;

    // one or two bytes to put on the bus; the second is always a command
    typedef struct packed {
        logic       rs0;
        logic [7:0] byte0;
        logic       two;
        logic [7:0] byte1;
    } job_t;

    function automatic logic [7:0] set_addr_cmd(input logic [5:0] col,
                                                input logic [1:0] row,
                                                input logic [6:0] eff_w);
        logic [6:0] off;
        logic [6:0] sum;
        begin
            case (row)
                2'd0:    off = 7'd0;
                2'd1:    off = ROW_ODD_OFFSET;
                2'd2:    off = eff_w;
                default: off = ROW_ODD_OFFSET + eff_w;
            endcase
            sum = {1'b0, col} + off;
            set_addr_cmd = SET_ADDR_FLAG | {1'b0, sum};
        end
    endfunction

endpackage

`default_nettype wire

@@ src/clbw_front.sv @@
// Front end: accepts items, tracks the cursor and builds bus jobs.
// Depends on clbw_pkg and the assertion header.
`default_nettype none
`include "char_lcd_cursor_bus_writer_unit_assert.svh"

module clbw_front #(
    parameter int MAX_WIDTH = 40,
    parameter int NUM_ROWS  = 4
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire clbw_pkg::cfg_t cfg,
    input  wire                 s_tvalid,
    output logic                s_tready,
    input  wire  [15:0]         s_tdata,   // value[7:0], column[13:8], row[15:14]
    input  wire  [2:0]          s_tuser,   // cmd[1:0], same_line[2]
    output logic                push,
    output clbw_pkg::job_t      push_job,
    input  wire                 push_ready
);
    import clbw_pkg::*;

    localparam logic [6:0] MAX_W = 7'(MAX_WIDTH);
    localparam logic [2:0] MAX_H = 3'(NUM_ROWS);

    logic [5:0] cursor_col_reg, cursor_col_next;
    logic [1:0] cursor_row_reg, cursor_row_next;

    logic [1:0] cmd;
    logic [7:0] value;
    logic [5:0] column;
    logic [1:0] row_in;
    logic       same_line;
    logic [6:0] eff_w;
    logic [2:0] eff_h;
    logic [6:0] col_inc;
    logic [2:0] row_inc;
    logic       wrap;
    logic       accept;

    assign cmd       = s_tuser[1:0];
    assign same_line = s_tuser[2];
    assign value     = s_tdata[7:0];
    assign column    = s_tdata[13:8];
    assign row_in    = s_tdata[15:14];

    assign s_tready = push_ready;
    assign push     = s_tvalid;
    assign accept   = s_tvalid && push_ready;

    always_comb begin
        if (cfg.width == 6'd0) begin
            eff_w = 7'd1;
        end else if ({1'b0, cfg.width} > MAX_W) begin
            eff_w = MAX_W;
        end else begin
            eff_w = {1'b0, cfg.width};
        end
        if (cfg.height == 3'd0) begin
            eff_h = 3'd1;
        end else if (cfg.height > MAX_H) begin
            eff_h = MAX_H;
        end else begin
            eff_h = cfg.height;
        end
    end

    assign col_inc = {1'b0, cursor_col_reg} + 7'd1;
    assign row_inc = {1'b0, cursor_row_reg} + 3'd1;
    assign wrap    = (col_inc >= eff_w);

    always_comb begin
        cursor_col_next = cursor_col_reg;
        cursor_row_next = cursor_row_reg;
        push_job.rs0    = RS_DATA;
        push_job.byte0  = value;
        push_job.two    = 1'b0;
        push_job.byte1  = 8'd0;
        case (cmd)
            CMD_WRITE_CHAR: begin
                if (wrap) begin
                    cursor_col_next = 6'd0;
                    if (!same_line) begin
                        cursor_row_next = (row_inc >= eff_h) ? 2'd0 : row_inc[1:0];
                    end
                end else begin
                    cursor_col_next = col_inc[5:0];
                end
                push_job.two   = wrap;
                push_job.byte1 = set_addr_cmd(cursor_col_next, cursor_row_next, eff_w);
            end
            CMD_SET_CURSOR: begin
                cursor_col_next = ({1'b0, column} >= eff_w) ? eff_w[5:0] : column;
                cursor_row_next = ({1'b0, row_in} >= eff_h) ? 2'(eff_h - 3'd1) : row_in;
                push_job.rs0    = RS_COMMAND;
                push_job.byte0  = set_addr_cmd(cursor_col_next, cursor_row_next, eff_w);
            end
            CMD_RAW_CMD: begin
                push_job.rs0 = RS_COMMAND;
            end
            default: begin
                push_job.rs0 = RS_DATA;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_col_reg <= 6'd0;
            cursor_row_reg <= 2'd0;
        end else if (accept) begin
            cursor_col_reg <= cursor_col_next;
            cursor_row_reg <= cursor_row_next;
        end
    end

    `CLBW_ASSERT(a_col_bounded, aclk, aresetn, ({1'b0, cursor_col_reg} <= MAX_W))

endmodule

`default_nettype wire

@@ src/clbw_queue.sv @@
// Short job queue between front and back ends.
// Depends on clbw_pkg and the assertion header.
`default_nettype none
`include "char_lcd_cursor_bus_writer_unit_assert.svh"

module clbw_queue (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 push,
    input  wire clbw_pkg::job_t push_job,
    output logic                push_ready,
    output logic                pop_valid,
    output clbw_pkg::job_t      pop_job,
    input  wire                 pop
);
    import clbw_pkg::*;

    localparam logic [QPTR_W:0] DEPTH = (QPTR_W + 1)'(QUEUE_DEPTH);

    job_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != DEPTH);
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = slot_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    `CLBW_ASSERT(a_count_bounded, aclk, aresetn, (count_reg <= DEPTH))
    `CLBW_ASSERT(a_pop_nonempty, aclk, aresetn, (pop |-> count_reg != '0))

endmodule

`default_nettype wire

@@ src/clbw_back.sv @@
// Back end: splits queued jobs into nibble or byte transfers, output register.
// Depends on clbw_pkg and the assertion header.
`default_nettype none
`include "char_lcd_cursor_bus_writer_unit_assert.svh"

module clbw_back (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire clbw_pkg::cfg_t cfg,
    input  wire                 job_valid,
    input  wire clbw_pkg::job_t job,
    output logic                job_pop,
    output logic                m_tvalid,
    input  wire                 m_tready,
    output logic [7:0]          m_tdata,   // bus_value[7:0]
    output logic                m_tuser,   // reg_select
    output logic                m_tlast
);
    import clbw_pkg::*;

    logic [1:0] phase_reg, phase_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic [7:0] m_tdata_reg;
    logic       m_tuser_reg;
    logic       m_tlast_reg;

    logic       load;
    logic       second;
    logic [7:0] cur_byte;
    logic       cur_rs;
    logic [7:0] bus_next;
    logic [1:0] last_phase;
    logic       is_last;

    assign load   = job_valid && (!m_tvalid_reg || m_tready);
    assign second = cfg.four_bit_mode ? phase_reg[1] : phase_reg[0];

    always_comb begin
        cur_byte = second ? job.byte1 : job.byte0;
        cur_rs   = second ? RS_COMMAND : job.rs0;
        if (cfg.four_bit_mode) begin
            bus_next   = phase_reg[0] ? {4'd0, cur_byte[3:0]} : {4'd0, cur_byte[7:4]};
            last_phase = job.two ? 2'd3 : 2'd1;
        end else begin
            bus_next   = cur_byte;
            last_phase = job.two ? 2'd1 : 2'd0;
        end
        is_last = (phase_reg == last_phase);
    end

    always_comb begin
        phase_next    = phase_reg;
        m_tvalid_next = m_tvalid_reg;
        if (load) begin
            phase_next    = is_last ? 2'd0 : phase_reg + 2'd1;
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    assign job_pop = load && is_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= 2'd0;
            m_tvalid_reg <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_tdata_reg <= bus_next;
            m_tuser_reg <= cur_rs;
            m_tlast_reg <= is_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    `CLBW_ASSERT(a_phase_restarts, aclk, aresetn, (job_pop |=> phase_reg == 2'd0))

endmodule

`default_nettype wire

@@ src/char_lcd_cursor_bus_writer_unit.sv @@
// Top level of the character-LCD bus writer: config registers, front, queue, back.
// Depends on clbw_pkg, clbw_front, clbw_queue, clbw_back.
//
//  channel | dir | payload                                      | sideband
//  s_      | in  | tdata: value[7:0] column[13:8] row[15:14]    | tuser: cmd[1:0] same_line[2]
//  m_      | out | tdata: bus_value[7:0]                        | tuser: reg_select, tlast: last
//  cfg_    | in  | cfg_index[1:0], cfg_data[5:0]                | cfg_ready always high
//
// A word is accepted every cycle while the four-entry job queue has room.
// The back end puts out one bus word per cycle while m_tready is high; an item takes 1, 2
// or 4 words there (one or two bytes, one or two nibbles each); the back end sets the rate.
// Output sits in a register; a stalled m_ side keeps filling the queue.
// Reset: cursor to 0, four_bit_mode 1, width 16, height 2, queue and output empty.
`default_nettype none

module char_lcd_cursor_bus_writer_unit #(
    parameter int MAX_WIDTH = 40,
    parameter int NUM_ROWS  = 4
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [15:0] s_tdata,    // value[7:0], column[13:8], row[15:14]
    input  wire  [2:0]  s_tuser,    // cmd[1:0], same_line[2]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [7:0]  m_tdata,    // bus_value[7:0]
    output logic        m_tuser,    // reg_select
    output logic        m_tlast,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [1:0]  cfg_index,
    input  wire  [5:0]  cfg_data
);
    import clbw_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    logic push;
    job_t push_job;
    logic push_ready;
    logic pop_valid;
    job_t pop_job;
    logic pop;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_IDX_FOUR_BIT: cfg_next.four_bit_mode = cfg_data[0];
                CFG_IDX_WIDTH:    cfg_next.width         = cfg_data;
                CFG_IDX_HEIGHT:   cfg_next.height        = cfg_data[2:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.four_bit_mode <= RESET_FOUR_BIT;
            cfg_reg.width         <= RESET_WIDTH;
            cfg_reg.height        <= RESET_HEIGHT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    clbw_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .NUM_ROWS  (NUM_ROWS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push       (push),
        .push_job   (push_job),
        .push_ready (push_ready)
    );

    clbw_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_job   (push_job),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_job    (pop_job),
        .pop        (pop)
    );

    clbw_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .job_valid (pop_valid),
        .job       (pop_job),
        .job_pop   (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire
